>>> hw/rtl/square_occupancy_grid_macros.svh
// Assertion macros shared by the square occupancy grid RTL.
// Included by the controller and the datapath; depends on nothing else.
`ifndef SQUARE_OCCUPANCY_GRID_MACROS_SVH
`define SQUARE_OCCUPANCY_GRID_MACROS_SVH

// Clocked check that is switched off while reset is high, with a message.
`define SOG_ASSERT_MSG(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check with a generic message.
`define SOG_ASSERT(name, clk, rst, prop) \
   `SOG_ASSERT_MSG(name, clk, rst, prop, "square occupancy grid check failed")

`endif

>>> hw/rtl/sog_pkg.sv
// Types and constants of the square occupancy grid.
// Used by the channel interfaces, the controller, the datapath and the top level.
package sog_pkg;

   localparam int FuncWidth  = 3;
   localparam int XyWidth    = 7;
   // Signed square coordinates; wide enough for corners that fall off the grid.
   localparam int CoordWidth = 9;

   typedef logic [FuncWidth-1:0]         func_bits_type;
   typedef logic [XyWidth-1:0]           xy_type;
   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_OCCUPY = 3'd0,
      FUNC_FREE   = 3'd1,
      FUNC_QUERY  = 3'd2,
      FUNC_CLEAR  = 3'd3,
      FUNC_SET    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;      // latch the accepted transaction and its square
      logic issue;     // read the current column and step to the next
      logic wipe;      // forget every column and set the background value
      logic wipe_val;
      logic take_hit;  // record the hit found by the query stage
      logic publish;   // move the recorded result to the output register
   } cmd_type;

   typedef struct packed {
      func_bits_type op;
      logic          empty;  // the square holds no column inside the grid
      logic          last;   // the current column is the last one
      logic          found;  // the query stage sees an occupied cell
      logic          busy;   // a column is still in the pipeline
   } stat_type;

endpackage

>>> hw/rtl/sog_req_if.sv
// Request channel of the square occupancy grid: valid, ready and the item.
// Depends on sog_pkg.
interface sog_req_if;
   import sog_pkg::*;

   logic          valid;
   logic          ready;
   func_bits_type func;
   xy_type        center_x;
   xy_type        center_y;
   xy_type        side;

   modport source (output valid, func, center_x, center_y, side, input ready);
   modport sink (input valid, func, center_x, center_y, side, output ready);
endinterface

>>> hw/rtl/sog_rsp_if.sv
// Response channel of the square occupancy grid: valid, ready and the result.
// Depends on sog_pkg.
interface sog_rsp_if;
   import sog_pkg::*;

   logic   valid;
   logic   ready;
   logic   hit;
   xy_type hit_x;
   xy_type hit_y;

   modport source (output valid, hit, hit_x, hit_y, input ready);
   modport sink (input valid, hit, hit_x, hit_y, output ready);
endinterface

>>> hw/rtl/sog_ctrl.sv
// Controller of the square occupancy grid: sequences one transaction at a time.
// Depends on sog_pkg and square_occupancy_grid_macros.svh.
`include "square_occupancy_grid_macros.svh"

module sog_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sog_pkg::cmd_type   cmd,
   input  sog_pkg::stat_type  stat
);
   import sog_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            priority if (stat.op == FUNC_OCCUPY || stat.op == FUNC_FREE ||
                         stat.op == FUNC_QUERY) begin
               state_in = stat.empty ? ST_FINISH : ST_SCAN;
            end else if (stat.op == FUNC_CLEAR || stat.op == FUNC_SET) begin
               cmd.wipe     = 1'b1;
               cmd.wipe_val = (stat.op == FUNC_SET);
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            // Columns read after the first hit are simply dropped.
            priority if (stat.found) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_FINISH;
            end else if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            priority if (stat.found) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_FINISH;
            end else if (!stat.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SOG_ASSERT(a_start_pipe_empty, clock, reset, (state_ff == ST_START) |-> !stat.busy)
   `SOG_ASSERT(a_publish_shows, clock, reset, cmd.publish |=> rsp_valid_ff)
   `SOG_ASSERT(a_scan_nonempty, clock, reset, (state_ff == ST_SCAN) |-> !stat.empty)
endmodule

>>> hw/rtl/sog_dpath.sv
// Datapath of the square occupancy grid: column memory, row mask and query stage.
// Depends on sog_pkg and square_occupancy_grid_macros.svh.
`include "square_occupancy_grid_macros.svh"

module sog_dpath #(
   parameter int GRID_SIZE = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sog_pkg::cmd_type        cmd,
   output sog_pkg::stat_type       stat,
   input  sog_pkg::func_bits_type  req_func,
   input  sog_pkg::xy_type         req_center_x,
   input  sog_pkg::xy_type         req_center_y,
   input  sog_pkg::xy_type         req_side,
   output logic                    rsp_hit,
   output sog_pkg::xy_type         rsp_hit_x,
   output sog_pkg::xy_type         rsp_hit_y
);
   import sog_pkg::*;

   localparam int        AddrWidth = $clog2(GRID_SIZE);
   localparam coord_type GridMax   = coord_type'(GRID_SIZE - 1);

   // One memory word per column x; bit y of the word is cell (x, y).
   logic [GRID_SIZE-1:0] mem [GRID_SIZE];

   // Square geometry of the request.
   coord_type            cx_c, cy_c, side_c, half_c;
   coord_type            x0_c, xe_raw_c, ytop_c, ybot_c, xs_c, xe_c;
   logic [GRID_SIZE-1:0] mask_c;

   func_bits_type        op_ff;
   coord_type            col_ff;
   coord_type            xe_ff;
   logic                 empty_ff;
   logic [GRID_SIZE-1:0] mask_ff;

   // Columns never written since the last wipe read as the background value.
   logic [GRID_SIZE-1:0] col_valid_ff;
   logic                 bg_ff;

   logic [AddrWidth-1:0] rd_addr;
   logic [GRID_SIZE-1:0] rdata_ff;
   logic                 s1_valid_ff;
   logic [AddrWidth-1:0] s1_col_ff;
   logic                 s1_cvalid_ff;
   logic [GRID_SIZE-1:0] s1_word;
   logic                 is_fill, is_query, wr_en;
   logic [GRID_SIZE-1:0] wr_data;

   logic                 s2_valid_ff;
   logic [AddrWidth-1:0] s2_col_ff;
   logic [GRID_SIZE-1:0] masked_ff;
   logic [AddrWidth-1:0] top_y;
   logic                 found;

   logic                 res_hit_ff;
   xy_type               res_x_ff, res_y_ff;
   logic                 rsp_hit_ff;
   xy_type               rsp_hit_x_ff, rsp_hit_y_ff;

   always_comb begin
      cx_c     = $signed({2'b00, req_center_x});
      cy_c     = $signed({2'b00, req_center_y});
      side_c   = $signed({2'b00, req_side});
      half_c   = (req_side == '0) ? coord_type'(0) : ((side_c - coord_type'(1)) >>> 1);
      x0_c     = cx_c - half_c;
      xe_raw_c = x0_c + side_c - coord_type'(1);
      ytop_c   = cy_c + half_c;
      ybot_c   = ytop_c - side_c + coord_type'(1);
      xs_c     = (x0_c < coord_type'(0)) ? coord_type'(0) : x0_c;
      xe_c     = (xe_raw_c > GridMax) ? GridMax : xe_raw_c;
      for (int y = 0; y < GRID_SIZE; y++) begin
         mask_c[y] = (coord_type'(y) >= ybot_c) && (coord_type'(y) <= ytop_c);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_func;
         xe_ff    <= xe_c;
         empty_ff <= (xs_c > xe_c);
         mask_ff  <= mask_c;
      end
      if (cmd.load) begin
         col_ff <= xs_c;
      end else if (cmd.issue) begin
         col_ff <= col_ff + coord_type'(1);
      end
   end

   assign rd_addr  = col_ff[AddrWidth-1:0];
   assign is_fill  = (op_ff == FUNC_OCCUPY) || (op_ff == FUNC_FREE);
   assign is_query = (op_ff == FUNC_QUERY);
   assign s1_word  = s1_cvalid_ff ? rdata_ff : {GRID_SIZE{bg_ff}};
   assign wr_en    = s1_valid_ff && is_fill;
   assign wr_data  = (op_ff == FUNC_OCCUPY) ? (s1_word | mask_ff) : (s1_word & ~mask_ff);

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rdata_ff     <= mem[rd_addr];
         s1_col_ff    <= rd_addr;
         s1_cvalid_ff <= col_valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem[s1_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
         bg_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (cmd.wipe) begin
            col_valid_ff <= '0;
            bg_ff        <= cmd.wipe_val;
         end else if (wr_en) begin
            col_valid_ff[s1_col_ff] <= 1'b1;
         end
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff && is_query;
      end
   end

   always_ff @(posedge clock) begin
      masked_ff <= s1_word & mask_ff;
      s2_col_ff <= s1_col_ff;
   end

   // The loop runs up from bit 0 and the last match stands, so the highest set bit wins.
   always_comb begin
      top_y = '0;
      for (int i = 0; i < GRID_SIZE; i++) begin
         if (masked_ff[i]) begin
            top_y = AddrWidth'(i);
         end
      end
   end

   assign found = s2_valid_ff && (|masked_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_hit_ff <= 1'b0;
         res_x_ff   <= '0;
         res_y_ff   <= '0;
      end else if (cmd.take_hit) begin
         res_hit_ff <= 1'b1;
         res_x_ff   <= xy_type'(s2_col_ff);
         res_y_ff   <= xy_type'(top_y);
      end
      if (cmd.publish) begin
         rsp_hit_ff   <= res_hit_ff;
         rsp_hit_x_ff <= res_x_ff;
         rsp_hit_y_ff <= res_y_ff;
      end
   end

   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_hit_x_ff;
   assign rsp_hit_y = rsp_hit_y_ff;

   always_comb begin
      stat       = '0;
      stat.op    = op_ff;
      stat.empty = empty_ff;
      stat.last  = (col_ff == xe_ff);
      stat.found = found;
      stat.busy  = s1_valid_ff || s2_valid_ff;
   end

   `SOG_ASSERT(a_col_in_range, clock, reset, s1_valid_ff |-> (coord_type'(s1_col_ff) <= xe_ff))
   `SOG_ASSERT(a_wipe_clears, clock, reset, cmd.wipe |=> (col_valid_ff == '0))
   `SOG_ASSERT(a_found_query, clock, reset, found |-> (op_ff == FUNC_QUERY))
endmodule

>>> hw/rtl/square_occupancy_grid.sv
// Square occupancy grid: one transaction at a time, one map column per cycle.
// A square write visits each of its columns inside the grid (at most GRID_SIZE); a query
// stops early at its first hit. Clear, set, unknown codes and a side of zero skip the
// column scan. The next transaction is accepted in the cycle the response first shows
// valid, so one transaction is finished before the next is taken.
// Synchronous reset empties the map at once through per-column valid bits.
module square_occupancy_grid #(
   parameter int GRID_SIZE = 128
) (
   input logic         clock,
   input logic         reset,
   sog_req_if.sink     req_ch,
   sog_rsp_if.source   rsp_ch
);
   import sog_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sog_dpath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_ch.func),
      .req_center_x (req_ch.center_x),
      .req_center_y (req_ch.center_y),
      .req_side     (req_ch.side),
      .rsp_hit      (rsp_ch.hit),
      .rsp_hit_x    (rsp_ch.hit_x),
      .rsp_hit_y    (rsp_ch.hit_y)
   );
endmodule
